// ===== sv/lru_page_replacement_defines.svh =====
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared macros for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define LRUPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that holds in the cycle after its trigger.
`define LRUPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Field widths, reset constants and the sequencer state type.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int PAGE_W  = 32;
   localparam int STAMP_W = 32;
   localparam int TOTAL_W = 32;
   localparam int CAP_W   = 11;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_WRITE
   } state_type;

endpackage

// ===== sv/lrupr_ram.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement slot RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lrupr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative set of resident pages with least recently used eviction.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Transfer
//   --------  -----------------------------  ---------------------------------
//   request   start, busy, req_*             start high while busy is low
//   result    rsp_valid, rsp_*               one cycle strobe, always taken
//   config    csr_valid, csr_ready, csr_data csr_valid and csr_ready high
//
// A miss holds busy high through one slot RAM read per filled slot, a step
// for the last read data, a step to close the scan, a decision step and a
// write-back step; with no slot filled, the scan closes at once. A hit ends
// the scan early and goes straight to the write-back step. Reset is
// synchronous and clears the fill count, the counters and the sequencer;
// the slot RAM needs no clearing pass because only the filled prefix of
// slots is ever read. The result is strobed in the first cycle with busy
// low, and the next access can be accepted at the edge that ends it. The
// receiver cannot stall the result.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
   parameter int RESIDENT_SLOTS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lrupr_pkg::PAGE_W-1:0]   req_page_number,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lrupr_pkg::CAP_W-1:0]    csr_data,
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic                           rsp_evicted,
   output logic [lrupr_pkg::PAGE_W-1:0]   rsp_evicted_page,
   output logic [lrupr_pkg::TOTAL_W-1:0]  rsp_reads_total,
   output logic [lrupr_pkg::TOTAL_W-1:0]  rsp_writes_total
);
   import lrupr_pkg::*;

   localparam int AW   = $clog2(RESIDENT_SLOTS);
   localparam int CW   = $clog2(RESIDENT_SLOTS + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
   localparam int RW   = PAGE_W + STAMP_W;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   // Sequencer and control state.
   state_type          state_ff, state_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [STAMP_W-1:0] use_clock_ff, use_clock_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [TOTAL_W-1:0] reads_ff, reads_in;
   logic [TOTAL_W-1:0] writes_ff, writes_in;
   logic [CW-1:0]      rd_cnt_ff, rd_cnt_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-access payload.
   logic [PAGE_W-1:0]  req_page_ff, req_page_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [AW-1:0]      pend_idx_ff, pend_idx_in;
   logic               best_found_ff, best_found_in;
   logic [STAMP_W-1:0] best_age_ff, best_age_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [PAGE_W-1:0]  best_page_ff, best_page_in;
   logic               hit_ff, hit_in;
   logic               ev_ff, ev_in;
   logic [PAGE_W-1:0]  ev_page_ff, ev_page_in;
   logic [AW-1:0]      target_ff, target_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_ev_ff, rsp_ev_in;
   logic [PAGE_W-1:0]  rsp_ev_page_ff, rsp_ev_page_in;

   // Slot RAM ports.
   logic               ram_rd_en;
   logic               ram_wr_en;
   logic [RW-1:0]      ram_rd_data;
   logic [PAGE_W-1:0]  rd_page;
   logic [STAMP_W-1:0] rd_stamp;
   logic [STAMP_W-1:0] rd_age;

   logic               accept;
   logic               issue;
   logic               match;
   logic               scan_done;
   logic [CAP_W-1:0]   cap_lo;
   logic               full;

   lrupr_ram #(
      .WIDTH (RW),
      .DEPTH (RESIDENT_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (target_ff),
      .wr_data ({req_page_ff, stamp_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Shared compare unit: page match and age of the slot just read.
   assign rd_page   = ram_rd_data[RW-1:STAMP_W];
   assign rd_stamp  = ram_rd_data[STAMP_W-1:0];
   assign rd_age    = use_clock_ff - rd_stamp;
   assign match     = pend_ff && (rd_page == req_page_ff);
   assign issue     = (rd_cnt_ff != count_ff);
   assign scan_done = !issue && !pend_ff;
   assign accept    = start && !busy;

   // The set is full once the fill count reaches the clamped capacity.
   assign cap_lo = (cap_ff == '0) ? CAP_W'(1) : cap_ff;
   assign full   = (CMPW'(count_ff) >= CMPW'(cap_lo)) || (count_ff == CW'(RESIDENT_SLOTS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               state_in = ST_WRITE;
            end else if (scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy      = 1'b1;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_SCAN:   ram_rd_en = issue;
         ST_DECIDE: ram_rd_en = 1'b0;
         ST_WRITE:  ram_wr_en = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   assign csr_ready = 1'b1;

   // Datapath next values.
   always_comb begin
      cap_in         = cap_ff;
      use_clock_in   = use_clock_ff;
      count_in       = count_ff;
      reads_in       = reads_ff;
      writes_in      = writes_ff;
      rd_cnt_in      = rd_cnt_ff;
      pend_in        = 1'b0;
      rsp_valid_in   = 1'b0;
      req_page_in    = req_page_ff;
      stamp_in       = stamp_ff;
      pend_idx_in    = pend_idx_ff;
      best_found_in  = best_found_ff;
      best_age_in    = best_age_ff;
      best_idx_in    = best_idx_ff;
      best_page_in   = best_page_ff;
      hit_in         = hit_ff;
      ev_in          = ev_ff;
      ev_page_in     = ev_page_ff;
      target_in      = target_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_ev_page_in = rsp_ev_page_ff;

      // Capacity register write.
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      case (state_ff)
         // Latch the access and stamp it with the use clock.
         ST_IDLE: begin
            if (accept) begin
               req_page_in   = req_page_number;
               stamp_in      = use_clock_ff;
               use_clock_in  = use_clock_ff + 1'b1;
               rd_cnt_in     = '0;
               best_found_in = 1'b0;
               hit_in        = 1'b0;
               ev_in         = 1'b0;
            end
         end
         // Walk the filled slots: look for a match and track the oldest.
         ST_SCAN: begin
            pend_in     = issue;
            pend_idx_in = rd_cnt_ff[AW-1:0];
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (match) begin
               hit_in    = 1'b1;
               target_in = pend_idx_ff;
               pend_in   = 1'b0;
            end else if (pend_ff && (!best_found_ff || (rd_age > best_age_ff))) begin
               best_found_in = 1'b1;
               best_age_in   = rd_age;
               best_idx_in   = pend_idx_ff;
               best_page_in  = rd_page;
            end
         end
         // Miss: take the next free slot, or evict the oldest once full.
         ST_DECIDE: begin
            if (!full) begin
               target_in = count_ff[AW-1:0];
               count_in  = count_ff + 1'b1;
            end else begin
               target_in  = best_idx_ff;
               ev_in      = 1'b1;
               ev_page_in = best_page_ff;
            end
         end
         // Write the slot back, update the totals and register the result.
         ST_WRITE: begin
            rsp_valid_in   = 1'b1;
            rsp_hit_in     = hit_ff;
            rsp_ev_in      = ev_ff;
            rsp_ev_page_in = ev_ff ? ev_page_ff : '0;
            if (!hit_ff) begin
               reads_in = sat_inc(reads_ff);
            end
            if (ev_ff) begin
               writes_in = sat_inc(writes_ff);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAPACITY_RESET;
         use_clock_ff <= '0;
         count_ff     <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         rd_cnt_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         use_clock_ff <= use_clock_in;
         count_ff     <= count_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         rd_cnt_ff    <= rd_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_page_ff    <= req_page_in;
      stamp_ff       <= stamp_in;
      pend_idx_ff    <= pend_idx_in;
      best_found_ff  <= best_found_in;
      best_age_ff    <= best_age_in;
      best_idx_ff    <= best_idx_in;
      best_page_ff   <= best_page_in;
      hit_ff         <= hit_in;
      ev_ff          <= ev_in;
      ev_page_ff     <= ev_page_in;
      target_ff      <= target_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_ev_page_ff <= rsp_ev_page_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evicted      = rsp_ev_ff;
   assign rsp_evicted_page = rsp_ev_page_ff;
   assign rsp_reads_total  = reads_ff;
   assign rsp_writes_total = writes_ff;

endmodule

// ===== sv/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement port checker
// Concurrent checks on the top level's ports, bound to every instance.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_defines.svh"

module lrupr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic                           rsp_hit,
   input logic                           rsp_evicted,
   input logic [lrupr_pkg::PAGE_W-1:0]   rsp_evicted_page,
   input logic [lrupr_pkg::TOTAL_W-1:0]  rsp_writes_total
);
   import lrupr_pkg::*;

   // An accepted access keeps the block busy in the following cycle.
   `LRUPR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not raise busy")

   // A result is strobed only as the block returns to idle.
   `LRUPR_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")

   // A hit never evicts.
   `LRUPR_ASSERT_SAME(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted, "hit with eviction")

   // Without an eviction the evicted page reads as zero.
   `LRUPR_ASSERT_SAME(a_evpage_zero, clock, reset, rsp_valid && !rsp_evicted, rsp_evicted_page == '0, "evicted page not zero")

   // An eviction is always counted in the write total.
   `LRUPR_ASSERT_SAME(a_evict_counted, clock, reset, rsp_valid && rsp_evicted, rsp_writes_total != '0, "eviction not counted")

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_hit          (rsp_hit),
   .rsp_evicted      (rsp_evicted),
   .rsp_evicted_page (rsp_evicted_page),
   .rsp_writes_total (rsp_writes_total)
);

// ===== tb/tb_lru_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page accesses through the start/busy command port and checks every
// result strobe against a cycle-free model of the resident set. The run
// starts at the reset capacity. It then moves through lowered, zero and small
// capacities and capacities at and above the slot count, then back to reset.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
   import lrupr_pkg::*;

   localparam int SLOT_COUNT   = 1024;
   localparam int CYCLE_LIMIT  = 6_000_000;
   localparam int DRAIN_CYCLES = SLOT_COUNT + 64;
   localparam int MAX_REPORTS  = 10;
   localparam int POOL_DEPTH   = 64;

   typedef struct packed {
      logic               hit;
      logic               evicted;
      logic [PAGE_W-1:0]  evicted_page;
      logic [TOTAL_W-1:0] reads_total;
      logic [TOTAL_W-1:0] writes_total;
   } access_result_type;

   // Ports of the block; its inputs are driven to known values from time zero.
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [PAGE_W-1:0]  req_page_number = '0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CAP_W-1:0]   csr_data = '0;
   logic               rsp_valid;
   logic               rsp_hit;
   logic               rsp_evicted;
   logic [PAGE_W-1:0]  rsp_evicted_page;
   logic [TOTAL_W-1:0] rsp_reads_total;
   logic [TOTAL_W-1:0] rsp_writes_total;

   // Shadow copy of the resident set.
   logic [PAGE_W-1:0]  lru_page [SLOT_COUNT];
   bit                 lru_valid [SLOT_COUNT];
   logic [STAMP_W-1:0] lru_stamp [SLOT_COUNT];
   logic [STAMP_W-1:0] access_clock;
   int                 fill_count;
   logic [TOTAL_W-1:0] load_count;
   logic [TOTAL_W-1:0] evict_count;
   logic [CAP_W-1:0]   capacity_reg;
   logic [PAGE_W-1:0]  last_victim;

   access_result_type  pending_results [$];
   int unsigned        mismatch_count;
   int unsigned        items_sent;
   int unsigned        results_seen;
   int unsigned        hits_seen;
   int unsigned        evictions_seen;
   int unsigned        capacity_writes;
   int unsigned        cycle_count;
   int                 burst_left;
   bit                 start_held;
   logic [PAGE_W-1:0]  page_pool [POOL_DEPTH];
   int                 pool_size;

   lru_page_replacement #(
      .RESIDENT_SLOTS(SLOT_COUNT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_page_number  (req_page_number),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_reads_total  (rsp_reads_total),
      .rsp_writes_total (rsp_writes_total)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one access to the shadow set and returns the result it should give.
   function automatic access_result_type lru_access(input logic [PAGE_W-1:0] page);
      access_result_type  res;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] age;
      logic [STAMP_W-1:0] best_age;
      int                 found;
      int                 target;
      int                 limit;
      int                 i;
      res = '0;
      stamp = access_clock;
      access_clock = access_clock + 1'b1;
      found = -1;
      target = -1;
      if (capacity_reg == 0)
         limit = 1;
      else if (capacity_reg > SLOT_COUNT)
         limit = SLOT_COUNT;
      else
         limit = int'(capacity_reg);

      for (i = 0; i < SLOT_COUNT; i++) begin
         if (found < 0 && lru_valid[i] && lru_page[i] == page)
            found = i;
      end

      if (found >= 0) begin
         // A hit only refreshes the page's last use.
         res.hit = 1'b1;
         lru_stamp[found] = stamp;
      end else begin
         if (fill_count < limit) begin
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (target < 0 && !lru_valid[i])
                  target = i;
            end
         end
         if (target >= 0) begin
            fill_count++;
         end else begin
            // The oldest page goes, and a tie goes to the lowest slot.
            best_age = '0;
            for (i = 0; i < SLOT_COUNT; i++) begin
               if (lru_valid[i]) begin
                  age = access_clock - lru_stamp[i];
                  if (target < 0 || age > best_age) begin
                     best_age = age;
                     target = i;
                  end
               end
            end
            if (target < 0) begin
               target = 0;
               fill_count = 1;
            end else begin
               res.evicted = 1'b1;
               res.evicted_page = lru_page[target];
               last_victim = lru_page[target];
               if (evict_count != '1)
                  evict_count = evict_count + 1'b1;
            end
         end
         lru_page[target] = page;
         lru_valid[target] = 1'b1;
         lru_stamp[target] = stamp;
         if (load_count != '1)
            load_count = load_count + 1'b1;
      end
      res.reads_total = load_count;
      res.writes_total = evict_count;
      return res;
   endfunction

   // Sends one access and waits for its transfer. Accesses go out in bursts;
   // at the end of a burst start drops for a random gap.
   task automatic send_page(input logic [PAGE_W-1:0] page);
      int gap;
      start <= 1'b1;
      req_page_number <= page;
      start_held = 1'b1;
      do @(posedge clock); while (busy);
      pending_results = {pending_results, lru_access(page)};
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         start_held = 1'b0;
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Lowers start and waits until every outstanding result has come back.
   task automatic wait_drained(input int unsigned extra);
      if (start_held) begin
         start <= 1'b0;
         start_held = 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Writes the capacity register while the block is idle.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_drained(2);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = value;
      capacity_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random accesses at one capacity: mostly resident pages and a small pool
   // of recurring pages, some re-accesses of the last victim, some fresh pages.
   task automatic random_phase(input logic [CAP_W-1:0] capacity, input int unsigned count);
      int unsigned       pick;
      int                k;
      logic [PAGE_W-1:0] page;
      write_capacity(capacity);
      pool_size = 2 * int'(capacity) + 2;
      if (pool_size > POOL_DEPTH)
         pool_size = POOL_DEPTH;
      for (k = 0; k < POOL_DEPTH; k++)
         page_pool[k] = $urandom;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 && fill_count > 0)
            page = lru_page[$urandom_range(0, fill_count - 1)];
         else if (pick < 75)
            page = page_pool[$urandom_range(0, pool_size - 1)];
         else if (pick < 88)
            page = last_victim;
         else
            page = $urandom;
         send_page(page);
      end
   endtask

   // Extreme page numbers and hits while the reset capacity applies.
   task automatic test_reset_capacity();
      send_page(32'h0000_0000);
      send_page(32'hFFFF_FFFF);
      send_page(32'h0000_0000);
      send_page(32'h8000_0000);
      send_page(32'hFFFF_FFFF);
      send_page(32'h5555_5555);
      send_page(32'hAAAA_AAAA);
      send_page(32'h0000_0001);
   endtask

   // Capacity below the resident count: old pages still hit, every miss evicts.
   task automatic test_lowered_capacity();
      write_capacity(11'd3);
      send_page(32'h8000_0000);
      send_page(32'h1234_5678);
      send_page(32'hFFFF_FFFF);
      send_page(32'h5555_5555);
      send_page(32'hDEAD_BEEF);
      send_page(32'h0000_0002);
   endtask

   // A capacity of zero behaves as one.
   task automatic test_capacity_floor();
      write_capacity('0);
      send_page(32'h7FFF_FFFF);
      send_page(32'h7FFF_FFFF);
      send_page(32'h0000_0003);
      write_capacity(11'd1);
      send_page(32'h0000_0004);
      send_page(32'h0000_0004);
   endtask

   // Random traffic over a range of small capacities.
   task automatic test_random_accesses();
      random_phase(11'd2, 60);
      random_phase(11'd8, 80);
      random_phase(11'd1, 40);
      random_phase(11'd16, 80);
      random_phase(11'd5, 60);
      random_phase(11'd24, 70);
      random_phase(11'd12, 60);
      random_phase(11'd32, 70);
   endtask

   // Capacities at and above the slot count, where the out-of-range value is
   // clamped, then back to the reset capacity.
   task automatic test_high_capacity();
      random_phase({CAP_W{1'b1}}, 15);
      random_phase(CAP_W'(SLOT_COUNT), 10);
      random_phase(CAPACITY_RESET, 15);
   endtask

   // Result checker: every strobe is a transfer and must match the oldest
   // outstanding prediction.
   always @(posedge clock) begin
      access_result_type got;
      access_result_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_hit, rsp_evicted, rsp_evicted_page, rsp_reads_total, rsp_writes_total};
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result with no access outstanding: hit=%0b evicted=%0b page=%h",
                        $time, got.hit, got.evicted, got.evicted_page);
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (want.hit)
               hits_seen++;
            if (want.evicted)
               evictions_seen++;
            if (got.hit !== want.hit || got.evicted !== want.evicted ||
                got.evicted_page !== want.evicted_page ||
                got.reads_total !== want.reads_total ||
                got.writes_total !== want.writes_total) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch expected hit=%0b evicted=%0b page=%h reads=%0d writes=%0d",
                           $time, want.hit, want.evicted, want.evicted_page,
                           want.reads_total, want.writes_total);
                  $display("%0t:          actual   hit=%0b evicted=%0b page=%h reads=%0d writes=%0d",
                           $time, got.hit, got.evicted, got.evicted_page,
                           got.reads_total, got.writes_total);
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int i;
      // The shadow set starts empty, as the block does after reset.
      for (i = 0; i < SLOT_COUNT; i++) begin
         lru_valid[i] = 1'b0;
         lru_page[i] = '0;
         lru_stamp[i] = '0;
      end
      access_clock = '0;
      fill_count = 0;
      load_count = '0;
      evict_count = '0;
      capacity_reg = CAPACITY_RESET;
      last_victim = '0;
      burst_left = 1;
      start_held = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_capacity();
      test_lowered_capacity();
      test_capacity_floor();
      test_random_accesses();
      test_high_capacity();

      wait_drained(DRAIN_CYCLES);
      $display("Sent %0d accesses across %0d capacity writes, from zero up to all ones.",
               items_sent, capacity_writes);
      $display("Checked %0d results with %0d hits, %0d evictions and %0d mismatches.",
               results_seen, hits_seen, evictions_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
